@@ src/assert_macros.svh @@
// assertion macros shared by the bloom filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bloom filter assertion failed");

// next-cycle implication, disabled during reset
`define BFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bloom filter assertion failed");

`endif

@@ src/bfm_pkg.sv @@
// types and constants for the bloom filter membership block
package bfm_pkg;

   localparam int HASH_W       = 32;
   localparam int FILTER_W     = 17;
   localparam int ENABLE_W     = 3;
   localparam int VERDICT_W    = 2;
   localparam int CSR_INDEX_W  = 8;
   localparam int RADIX_BITS   = 2;
   localparam int DIV_STEPS    = HASH_W / RADIX_BITS;
   localparam int STEP_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [FILTER_W-1:0] FILTER_BITS_RESET = 17'd65536;
   localparam logic [ENABLE_W-1:0] HASH_ENABLE_RESET = 3'd7;

   localparam logic [1:0] SLOT_A    = 2'd0;
   localparam logic [1:0] SLOT_B    = 2'd1;
   localparam logic [1:0] SLOT_C    = 2'd2;
   localparam logic [1:0] SLOT_DONE = 2'd3;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   localparam logic [VERDICT_W-1:0] VERDICT_ABSENT  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PRESENT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_ADDED   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_BITS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_ENABLE = 8'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SELECT,
      ST_DIVIDE,
      ST_PROBE,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

@@ src/bloom_filter_membership_top.sv @@
// bloom filter membership top level: shared remainder unit and bit store sequencer
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_ready      req_operation, req_hash_a/b/c
//   rsp       out         rsp_valid / rsp_ready      rsp_verdict
//   csr       in          csr_write_enable           csr_index, csr_write_data
//
// after reset the bit store is swept to zero, one bit a cycle, with req_ready low throughout the sweep
// an item passes ST_SELECT for each hash slot; an enabled slot then runs ST_DIVIDE in the
// 2-bit-a-cycle remainder unit and ST_PROBE into the single-port bit store (plus ST_CHECK for
// a check), then ST_FINISH; req_ready is high only while the sequencer is idle
// the result sits in an output register, so a stalled rsp only holds the next item at its end
`include "assert_macros.svh"

module bloom_filter_membership_top #(
   parameter int MAX_BITS = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [bfm_pkg::HASH_W-1:0]        req_hash_a,
   input  logic [bfm_pkg::HASH_W-1:0]        req_hash_b,
   input  logic [bfm_pkg::HASH_W-1:0]        req_hash_c,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bfm_pkg::VERDICT_W-1:0]     rsp_verdict,
   input  logic                              csr_write_enable,
   input  logic [bfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfm_pkg::FILTER_W-1:0]      csr_write_data
);
   import bfm_pkg::*;

   localparam int AW = $clog2(MAX_BITS);
   localparam int MW = $clog2(MAX_BITS + 1);

   state_type                state_ff, state_in;
   logic [FILTER_W-1:0]      filter_bits_ff;
   logic [ENABLE_W-1:0]      hash_enable_ff;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [1:0]               slot_ff, slot_in;
   logic [STEP_CNT_W-1:0]    step_ff, step_in;
   logic [HASH_W-1:0]        dividend_ff, dividend_in;
   logic [MW-1:0]            rem_ff, rem_in;
   logic [MW-1:0]            mod_ff, mod_in;
   logic                     op_ff, op_in;
   logic [HASH_W-1:0]        hash_a_ff, hash_b_ff, hash_c_ff;
   logic                     present_ff, present_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]     rsp_verdict_ff, rsp_verdict_in;
   logic                     rd_bit_ff;

   logic                     store_mem [MAX_BITS];
   logic                     mem_we, mem_re, mem_wdata;
   logic [AW-1:0]            mem_addr;

   logic                     accept;
   logic [HASH_W-1:0]        slot_hash;
   logic [MW-1:0]            rem_step;
   logic [31:0]              fb_wide;
   logic [MW-1:0]            mod_clamped;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // modulus saturates to 1 .. MAX_BITS
   assign fb_wide = 32'(filter_bits_ff);
   always_comb begin
      if (fb_wide == 32'd0) begin
         mod_clamped = MW'(1);
      end else if (fb_wide > 32'(MAX_BITS)) begin
         mod_clamped = MW'(MAX_BITS);
      end else begin
         mod_clamped = MW'(fb_wide);
      end
   end

   always_comb begin
      case (slot_ff)
         SLOT_A:  slot_hash = hash_a_ff;
         SLOT_B:  slot_hash = hash_b_ff;
         default: slot_hash = hash_c_ff;
      endcase
   end

   // shared remainder unit: two restoring steps per cycle
   always_comb begin
      logic [MW:0]   trial;
      logic [MW-1:0] r;
      r     = rem_ff;
      trial = '0;
      for (int k = 0; k < RADIX_BITS; k++) begin
         trial = {r, dividend_ff[HASH_W-1-k]};
         if (trial >= {1'b0, mod_ff}) begin
            trial = trial - {1'b0, mod_ff};
         end
         r = trial[MW-1:0];
      end
      rem_step = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= FILTER_BITS_RESET;
         hash_enable_ff <= HASH_ENABLE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FILTER_BITS: filter_bits_ff <= csr_write_data;
            CSR_HASH_ENABLE: hash_enable_ff <= csr_write_data[ENABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         slot_ff      <= SLOT_A;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      mod_ff         <= mod_in;
      op_ff          <= op_in;
      present_ff     <= present_in;
      rsp_verdict_ff <= rsp_verdict_in;
      if (accept) begin
         hash_a_ff <= req_hash_a;
         hash_b_ff <= req_hash_b;
         hash_c_ff <= req_hash_c;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_bit_ff <= store_mem[mem_addr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      step_in        = step_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      mod_in         = mod_ff;
      op_in          = op_ff;
      present_in     = present_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_wdata      = 1'b0;
      mem_addr       = rem_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_operation;
               mod_in     = mod_clamped;
               present_in = 1'b1;
               slot_in    = SLOT_A;
               state_in   = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (slot_ff == SLOT_DONE) begin
               state_in = ST_FINISH;
            end else if (hash_enable_ff[slot_ff]) begin
               dividend_in = slot_hash;
               rem_in      = '0;
               step_in     = '0;
               state_in    = ST_DIVIDE;
            end else begin
               slot_in = slot_ff + 2'd1;
            end
         end
         ST_DIVIDE: begin
            rem_in      = rem_step;
            dividend_in = dividend_ff << RADIX_BITS;
            step_in     = step_ff + STEP_CNT_W'(1);
            if (step_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (op_ff == OP_ADD) begin
               mem_we    = 1'b1;
               mem_wdata = 1'b1;
               slot_in   = slot_ff + 2'd1;
               state_in  = ST_SELECT;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            present_in = present_ff && rd_bit_ff;
            slot_in    = slot_ff + 2'd1;
            state_in   = ST_SELECT;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_ADD) begin
                  rsp_verdict_in = VERDICT_ADDED;
               end else if (present_ff) begin
                  rsp_verdict_in = VERDICT_PRESENT;
               end else begin
                  rsp_verdict_in = VERDICT_ABSENT;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `BFM_ASSERT_NEXT(a_accept_starts_slot_a, clock, reset, accept,
                    state_ff == ST_SELECT && slot_ff == SLOT_A)
   `BFM_ASSERT_IMPLY(a_rem_below_mod, clock, reset,
                     state_ff == ST_DIVIDE || state_ff == ST_PROBE, rem_ff < mod_ff)
   `BFM_ASSERT_IMPLY(a_mod_in_range, clock, reset,
                     state_ff == ST_DIVIDE || state_ff == ST_PROBE,
                     mod_ff != '0 && 32'(mod_ff) <= 32'(MAX_BITS))
   `BFM_ASSERT_NEXT(a_finish_loads_rsp, clock, reset,
                    state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready),
                    rsp_valid_ff && state_ff == ST_IDLE)

endmodule
